>>> src/tx_buffer_pool_send_queue_core_assert.svh
// Assertion macros used by the port-level checker.
`ifndef TX_BUFFER_POOL_SEND_QUEUE_CORE_ASSERT_SVH
`define TX_BUFFER_POOL_SEND_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TXBPSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define TXBPSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> src/txbpsq_pkg.sv
// Shared constants, codes and payload types of the send queue core.
package txbpsq_pkg;

    localparam int SLOTS      = 5;
    localparam int MAX_LENGTH = 1024;

    localparam int ACT_W  = 2;
    localparam int SLOT_W = 3;
    localparam int LEN_W  = 11;
    localparam int POS_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [ACT_W-1:0] ACT_CLAIM    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SUBMIT   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POLL     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_COMPLETE = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  length;
    } t_req;

    typedef struct packed {
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic              queued;
        logic              start_send;
        logic [SLOT_W-1:0] send_slot;
        logic [LEN_W-1:0]  send_length;
        logic              queue_empty;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

>>> src/txbpsq_if.sv
// Valid/ready channel interfaces for requests and responses.
interface txbpsq_req_if;
    import txbpsq_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface txbpsq_rsp_if;
    import txbpsq_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/txbpsq_ctrl.sv
// Controller: request intake, execute sequencing and response valid.
module txbpsq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output txbpsq_pkg::t_cmd  o_cmd
);
    import txbpsq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_rsp_valid, n_rsp_valid;
    logic out_free;

    // refuse requests while reset is held
    assign o_req_ready = i_rst_n && (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign out_free    = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state       = r_state;
        n_rsp_valid   = r_rsp_valid && !i_rsp_ready;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold the request until the output register can take the response
                if (out_free) begin
                    o_cmd.execute = 1'b1;
                    n_rsp_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

>>> src/txbpsq_dp.sv
// Datapath: slot ring, length store, transmitter flags and response register.
module txbpsq_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  txbpsq_pkg::t_cmd  i_cmd,
    input  txbpsq_pkg::t_req  i_req,
    output txbpsq_pkg::t_rsp  o_rsp
);
    import txbpsq_pkg::*;

    t_req r_req;
    t_rsp r_rsp, n_rsp;

    logic [SLOT_W-1:0] r_entries [SLOTS];
    logic [LEN_W-1:0]  r_lengths [SLOTS];

    logic [POS_W-1:0] r_head, n_head;
    logic [POS_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_tx_idle, n_tx_idle;
    logic             r_from_q, n_from_q;

    logic [SLOTS-1:0] pos_busy;
    logic [SLOTS-1:0] slot_queued;
    logic [POS_W-1:0] offset;
    logic [LEN_W-1:0] sat_len;
    logic             sub_ok;
    logic [SLOT_W-1:0] head_slot;
    logic [LEN_W-1:0]  head_len;

    function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p);
        return (p == POS_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    // Ring occupancy per position, then membership per slot number.
    always_comb begin
        pos_busy    = '0;
        slot_queued = '0;
        offset      = '0;
        for (int p = 0; p < SLOTS; p++) begin
            if (POS_W'(p) >= r_tail) begin
                offset = POS_W'(p) - r_tail;
            end else begin
                offset = POS_W'(p + SLOTS) - r_tail;
            end
            pos_busy[p] = (CNT_W'(offset) < r_count);
        end
        for (int s = 0; s < SLOTS; s++) begin
            for (int p = 0; p < SLOTS; p++) begin
                if (pos_busy[p] && (r_entries[p] == SLOT_W'(s))) begin
                    slot_queued[s] = 1'b1;
                end
            end
        end
    end

    assign sat_len   = (r_req.length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : r_req.length;
    assign sub_ok    = (r_count < CNT_W'(SLOTS)) && (r_req.slot < SLOT_W'(SLOTS));
    assign head_slot = r_entries[r_tail];
    assign head_len  = r_lengths[head_slot];

    always_comb begin
        n_rsp     = '0;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_tx_idle = r_tx_idle;
        n_from_q  = r_from_q;
        case (r_req.action)
            ACT_CLAIM: begin
                // scan down so the lowest free slot wins
                for (int s = SLOTS - 1; s >= 0; s--) begin
                    if (!slot_queued[s]) begin
                        n_rsp.free_found = 1'b1;
                        n_rsp.free_slot  = SLOT_W'(s);
                    end
                end
            end
            ACT_SUBMIT: begin
                if (sub_ok) begin
                    n_head       = wrap_inc(r_head);
                    n_count      = r_count + 1'b1;
                    n_rsp.queued = 1'b1;
                    // queue was empty and transmitter idle: new slot is the head, forward it directly
                    if ((r_count == '0) && r_tx_idle) begin
                        n_rsp.start_send  = 1'b1;
                        n_rsp.send_slot   = r_req.slot;
                        n_rsp.send_length = sat_len;
                        n_tx_idle         = 1'b0;
                        n_from_q          = 1'b1;
                    end
                end
            end
            ACT_POLL: begin
                if (r_tx_idle && (r_count != '0)) begin
                    n_rsp.start_send  = 1'b1;
                    n_rsp.send_slot   = head_slot;
                    n_rsp.send_length = head_len;
                    n_tx_idle         = 1'b0;
                    n_from_q          = 1'b1;
                end
            end
            ACT_COMPLETE: begin
                if (r_from_q && (r_count != '0)) begin
                    n_tail  = wrap_inc(r_tail);
                    n_count = r_count - 1'b1;
                end
                n_from_q  = 1'b0;
                n_tx_idle = 1'b1;
            end
            default: n_rsp = '0;
        endcase
        n_rsp.queue_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.execute) begin
            r_rsp <= n_rsp;
            if ((r_req.action == ACT_SUBMIT) && sub_ok) begin
                r_entries[r_head]      <= r_req.slot;
                r_lengths[r_req.slot]  <= sat_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_tx_idle <= 1'b1;
            r_from_q  <= 1'b0;
        end else if (i_cmd.execute) begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_tx_idle <= n_tx_idle;
            r_from_q  <= n_from_q;
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> src/tx_buffer_pool_send_queue_core.sv
// Transmit buffer pool and send queue: top level.
//
// Requests arrive on i_req (action, slot, length); one response per request
// leaves on o_rsp. Both channels are valid/ready; a request moves at a clock
// edge where valid and ready are both high.
// Actions: claim the lowest unqueued slot, submit a slot with a length,
// poll to start the head slot, and report transmit complete.
// The controller registers the request, then executes it against the
// five-entry ring and its membership compare once the output register
// is free; a new request is not taken until the executing one is done.
// The response sits in an output register, so the next request is taken
// while the previous response still waits. If the receiver stalls, the
// executing request is held until the output register frees up, and
// i_req.ready stays low meanwhile.
// Reset (i_rst_n low, synchronous) empties the queue, marks the transmitter
// idle and drops any pending response. Slot and length stores are not
// cleared; the queue discipline never reads an unwritten entry.
module tx_buffer_pool_send_queue_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    txbpsq_req_if.sink    i_req,
    txbpsq_rsp_if.source  o_rsp
);
    import txbpsq_pkg::*;

    t_cmd cmd;

    txbpsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    txbpsq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.data),
        .o_rsp   (o_rsp.data)
    );

endmodule

>>> src/txbpsq_checker.sv
// Port-level checker for the send queue core, with its bind.
`include "tx_buffer_pool_send_queue_core_assert.svh"

module txbpsq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input txbpsq_pkg::t_rsp i_rsp
);
    import txbpsq_pkg::*;

    logic stalled;
    logic send_ok;

    assign stalled = i_rsp_valid && !i_rsp_ready;
    assign send_ok = i_rsp.start_send ? (i_rsp.send_length <= LEN_W'(MAX_LENGTH))
                   : ((i_rsp.send_slot == '0) && (i_rsp.send_length == '0));

    `TXBPSQ_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, stalled, i_rsp_valid && $stable(i_rsp))
    `TXBPSQ_ASSERT_IMPL(a_send_fields, i_clk, i_rst_n, i_rsp_valid, send_ok)
    `TXBPSQ_ASSERT_IMPL(a_queued_not_empty, i_clk, i_rst_n, i_rsp_valid && i_rsp.queued, !i_rsp.queue_empty)
    `TXBPSQ_ASSERT_IMPL(a_no_free_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp.free_found, i_rsp.free_slot == '0)

endmodule

bind tx_buffer_pool_send_queue_core txbpsq_checker u_txbpsq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.data)
);

>>> tb/send_queue_check.sv
// Watches both channels, predicts every response of the send queue core and compares.
module send_queue_check (
    input  logic  i_clk,
    input  logic  i_rst_n,
    txbpsq_req_if i_req,
    txbpsq_rsp_if i_rsp,
    output int    o_fail_count,
    output int    o_pending
);
    import txbpsq_pkg::*;

    // Mirror of the pool: ring of queued slot numbers and stored lengths.
    logic [SLOT_W-1:0] ring_slot [SLOTS];
    logic [LEN_W-1:0]  stored_len [SLOTS];
    int                ins_pos;
    int                out_pos;
    int                depth;
    logic              tx_idle;
    logic              tx_from_ring;

    t_rsp              awaited_rsp [$];
    int                fail_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fail_total   = 0;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_total++;
    endtask

    // Start sending the head slot when the transmitter is free.
    function automatic void launch_head(inout t_rsp r);
        if (tx_idle && depth != 0) begin
            tx_from_ring  = 1'b1;
            tx_idle       = 1'b0;
            r.start_send  = 1'b1;
            r.send_slot   = ring_slot[out_pos];
            r.send_length = stored_len[ring_slot[out_pos]];
        end
    endfunction

    function automatic t_rsp advance_pool(t_req q);
        t_rsp             r;
        logic             hit;
        logic [LEN_W-1:0] len;
        r = '0;
        case (q.action)
            ACT_CLAIM: begin
                for (int s = 0; s < SLOTS; s++) begin
                    hit = 1'b0;
                    for (int k = 0; k < depth; k++)
                        if (ring_slot[(out_pos + k) % SLOTS] == SLOT_W'(s)) hit = 1'b1;
                    if (!hit && !r.free_found) begin
                        r.free_found = 1'b1;
                        r.free_slot  = SLOT_W'(s);
                    end
                end
            end
            ACT_SUBMIT: begin
                if (depth < SLOTS && q.slot < SLOTS) begin
                    // clamp oversized lengths before storing
                    len = (q.length > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : q.length;
                    stored_len[q.slot] = len;
                    ring_slot[ins_pos] = q.slot;
                    ins_pos  = (ins_pos + 1) % SLOTS;
                    depth++;
                    r.queued = 1'b1;
                    if (depth == 1) launch_head(r);
                end
            end
            ACT_POLL: launch_head(r);
            default: begin
                if (tx_from_ring && depth > 0) begin
                    out_pos = (out_pos + 1) % SLOTS;
                    depth--;
                end
                tx_from_ring = 1'b0;
                tx_idle      = 1'b1;
            end
        endcase
        r.queue_empty = (depth == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp g;
        t_rsp w;
        if (!i_rst_n) begin
            ins_pos      = 0;
            out_pos      = 0;
            depth        = 0;
            tx_idle      = 1'b1;
            tx_from_ring = 1'b0;
            awaited_rsp.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                g = i_rsp.data;
                if (awaited_rsp.size() == 0) begin
                    report("response with no request outstanding", 32'(g), 0);
                end else begin
                    w = awaited_rsp.pop_front();
                    if (g.free_found !== w.free_found)
                        report("free_found", 32'(g.free_found), 32'(w.free_found));
                    if (g.free_slot !== w.free_slot)
                        report("free_slot", 32'(g.free_slot), 32'(w.free_slot));
                    if (g.queued !== w.queued)
                        report("queued", 32'(g.queued), 32'(w.queued));
                    if (g.start_send !== w.start_send)
                        report("start_send", 32'(g.start_send), 32'(w.start_send));
                    if (g.send_slot !== w.send_slot)
                        report("send_slot", 32'(g.send_slot), 32'(w.send_slot));
                    if (g.send_length !== w.send_length)
                        report("send_length", 32'(g.send_length), 32'(w.send_length));
                    if (g.queue_empty !== w.queue_empty)
                        report("queue_empty", 32'(g.queue_empty), 32'(w.queue_empty));
                end
            end
            if (i_req.valid && i_req.ready)
                awaited_rsp.push_back(advance_pool(i_req.data));
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_rsp.size();
    end

endmodule

>>> tb/tx_buffer_pool_send_queue_core_tb.sv
// Testbench top: clock, reset, request stimulus, response stalls and the verdict.
module tx_buffer_pool_send_queue_core_tb;
    import txbpsq_pkg::*;

    localparam int RANDOM_REQS = 630;
    localparam int QUIET_TAIL  = 100;
    localparam int HANG_LIMIT  = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    int   gap_odds   = 4;   // 1-in-N chance of an idle burst, 0 for none
    int   hang_count = 0;

    txbpsq_req_if req_ch ();
    txbpsq_rsp_if rsp_ch ();

    always #1 i_clk = ~i_clk;

    tx_buffer_pool_send_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    send_queue_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Receiver: drop ready in random bursts.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
                stall_left   = $urandom_range(1, 11) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            hang_count <= 0;
        end else if (hang_count >= HANG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            hang_count <= hang_count + 1;
        end
    end

    task automatic issue(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] slot,
                         logic [LEN_W-1:0] len);
        t_req q;
        q.action = act;
        q.slot   = slot;
        q.length = len;
        if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Hold requests until every outstanding response has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    initial begin
        int               pick;
        logic [ACT_W-1:0] act;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0] len;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(ACT_CLAIM,    3'd0, 11'd0);
        issue(ACT_POLL,     3'd0, 11'd0);      // nothing queued
        issue(ACT_COMPLETE, 3'd0, 11'd0);      // complete while idle
        issue(ACT_SUBMIT,   3'd7, 11'd5);      // slot out of range
        issue(ACT_SUBMIT,   3'd5, 11'd0);
        issue(ACT_SUBMIT,   3'd0, 11'd2047);   // clamped, starts send
        issue(ACT_SUBMIT,   3'd0, 11'd0);      // same slot again, length rewritten
        issue(ACT_POLL,     3'd0, 11'd0);      // transmitter busy
        issue(ACT_SUBMIT,   3'd1, 11'd1);
        issue(ACT_SUBMIT,   3'd2, 11'd1024);
        issue(ACT_SUBMIT,   3'd3, 11'd1025);   // queue now full
        issue(ACT_SUBMIT,   3'd4, 11'd7);      // rejected, full
        issue(ACT_CLAIM,    3'd0, 11'd0);
        issue(ACT_COMPLETE, 3'd0, 11'd0);
        issue(ACT_POLL,     3'd0, 11'd0);
        issue(ACT_SUBMIT,   3'd4, 11'd1000);   // every slot queued
        issue(ACT_CLAIM,    3'd0, 11'd0);      // nothing free
        issue(ACT_COMPLETE, 3'd0, 11'd0);
        issue(ACT_COMPLETE, 3'd0, 11'd0);      // not from the queue
        issue(ACT_POLL,     3'd0, 11'd0);
        issue(ACT_COMPLETE, 3'd6, 11'd2047);
        issue(ACT_POLL,     3'd0, 11'd0);
        issue(ACT_COMPLETE, 3'd0, 11'd0);
        drain();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n >= RANDOM_REQS - QUIET_TAIL)
                gap_odds = 0;
            else if (n % 50 == 0)
                case ($urandom_range(0, 2))
                    0: gap_odds = 0;
                    1: gap_odds = 3;
                    default: gap_odds = 8;
                endcase
            if (n == RANDOM_REQS / 2) drain();
            pick = $urandom_range(0, 99);
            act  = (pick < 35) ? ACT_SUBMIT : (pick < 55) ? ACT_POLL :
                   (pick < 80) ? ACT_COMPLETE : ACT_CLAIM;
            slot = ($urandom_range(0, 9) < 8) ? SLOT_W'($urandom_range(0, SLOTS - 1))
                                             : SLOT_W'($urandom_range(SLOTS, 7));
            case ($urandom_range(0, 9))
                0: len = '0;
                1: len = LEN_W'(MAX_LENGTH);
                2: len = LEN_W'($urandom_range(MAX_LENGTH + 1, 2047));
                default: len = LEN_W'($urandom_range(0, MAX_LENGTH));
            endcase
            issue(act, slot, len);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
